// File: src/stt_pkg.sv
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Token kinds, the token and event records, and the sizes shared by the
// scanner, the event queue, the result stage and the checker.
// ----------------------------------------------------------------------------
package stt_pkg;

   // Width of the internal byte offset counter; it saturates at its top value.
   localparam int OFFSET_WIDTH = 24;

   // Widths of the reported fields.
   localparam int POS_W  = 16;
   localparam int OUT_W  = 24;
   localparam int KIND_W = 4;
   localparam int CHAR_W = 8;

   // Depth of the event queue between scanner and result stage.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Token kinds.
   localparam logic [KIND_W-1:0] KIND_END       = 4'd0;
   localparam logic [KIND_W-1:0] KIND_KEYWORD   = 4'd1;
   localparam logic [KIND_W-1:0] KIND_IDENT     = 4'd2;
   localparam logic [KIND_W-1:0] KIND_INTEGER   = 4'd3;
   localparam logic [KIND_W-1:0] KIND_STRING    = 4'd4;
   localparam logic [KIND_W-1:0] KIND_OPERATOR  = 4'd5;
   localparam logic [KIND_W-1:0] KIND_PUNCT     = 4'd6;
   localparam logic [KIND_W-1:0] KIND_UNTERM    = 4'd7;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN   = 4'd8;

   // One finished token.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  line;
      logic [POS_W-1:0]  column;
      logic [OUT_W-1:0]  offset;
      logic [OUT_W-1:0]  length;
      logic [CHAR_W-1:0] chr;
   } token_type;

   // All tokens caused by one request byte: one, or two when two is set.
   typedef struct packed {
      logic      two;
      token_type first;
      token_type second;
   } event_type;

   // Brings an internal offset to the reported width.
   function automatic logic [OUT_W-1:0] to_out(input logic [OFFSET_WIDTH-1:0] v);
      logic [63:0] wide;
      wide = 64'(v);
      return wide[OUT_W-1:0];
   endfunction

endpackage

// File: src/stt_front.sv
// ----------------------------------------------------------------------------
// Tokenizer scanner
// Accepts one source byte per cycle unless the queue is full, tracks position
// and scan mode, and hands every byte's finished tokens to the event queue as one event.
// ----------------------------------------------------------------------------
module stt_front
   import stt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [CHAR_W-1:0]   req_ch,
   input  logic                queue_full,
   output logic                evt_valid,
   output event_type           evt
);

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_IDENT  = 4'b0010,
      MODE_NUMBER = 4'b0100,
      MODE_STRING = 4'b1000
   } mode_type;

   typedef enum logic [1:0] {
      KW_NONE   = 2'd0,
      KW_INT    = 2'd1,
      KW_RETURN = 2'd2
   } kw_type;

   localparam logic [OFFSET_WIDTH-1:0] OFS_MAX = '1;
   localparam logic [POS_W-1:0]        POS_MAX = '1;
   localparam logic [POS_W-1:0]        POS_ONE = POS_W'(1);

   // Character classes.
   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "_";
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   // Keyword spellings, one letter per position.
   function automatic logic [7:0] int_char(input logic [2:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0:    r = "i";
         3'd1:    r = "n";
         3'd2:    r = "t";
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] return_char(input logic [2:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0:    r = "r";
         3'd1:    r = "e";
         3'd2:    r = "t";
         3'd3:    r = "u";
         3'd4:    r = "r";
         3'd5:    r = "n";
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   function automatic token_type make_token(
      input logic [KIND_W-1:0]       kind,
      input logic [POS_W-1:0]        line,
      input logic [POS_W-1:0]        column,
      input logic [OFFSET_WIDTH-1:0] ofs,
      input logic [OFFSET_WIDTH-1:0] len,
      input logic [CHAR_W-1:0]       chr
   );
      token_type t;
      t.kind   = kind;
      t.line   = line;
      t.column = column;
      t.offset = to_out(ofs);
      t.length = to_out(len);
      t.chr    = chr;
      return t;
   endfunction

   mode_type                mode_ff, mode_in;
   kw_type                  kw_ff, kw_in;
   logic [POS_W-1:0]        cur_line_ff, cur_line_in;
   logic [POS_W-1:0]        cur_col_ff, cur_col_in;
   logic [OFFSET_WIDTH-1:0] cur_ofs_ff, cur_ofs_in;
   logic [POS_W-1:0]        start_line_ff, start_line_in;
   logic [POS_W-1:0]        start_col_ff, start_col_in;
   logic [OFFSET_WIDTH-1:0] start_ofs_ff, start_ofs_in;

   logic                    accept;
   logic [OFFSET_WIDTH-1:0] len;
   logic [POS_W-1:0]        adv_line, adv_col;
   logic [OFFSET_WIDTH-1:0] adv_ofs;
   logic                    kw_match, kw_done;
   logic                    do_scan, have_first, have_scan;
   token_type               first_tok, scan_tok;

   assign accept = push && !queue_full;
   assign len    = cur_ofs_ff - start_ofs_ff;

   // Position after the current byte, all counters saturating.
   always_comb begin
      adv_ofs  = (cur_ofs_ff == OFS_MAX) ? cur_ofs_ff : cur_ofs_ff + 1'b1;
      adv_line = cur_line_ff;
      adv_col  = cur_col_ff;
      if (req_ch == 8'h0a) begin
         if (cur_line_ff != POS_MAX) begin
            adv_line = cur_line_ff + 1'b1;
         end
         adv_col = POS_ONE;
      end else if (cur_col_ff != POS_MAX) begin
         adv_col = cur_col_ff + 1'b1;
      end
   end

   // Keyword tracking: the letter position is the identifier length so far.
   assign kw_match = (kw_ff == KW_INT && len < OFFSET_WIDTH'(3)
                      && req_ch == int_char(len[2:0]))
                  || (kw_ff == KW_RETURN && len < OFFSET_WIDTH'(6)
                      && req_ch == return_char(len[2:0]));
   assign kw_done  = (kw_ff == KW_INT && len == OFFSET_WIDTH'(3))
                  || (kw_ff == KW_RETURN && len == OFFSET_WIDTH'(6));

   // Scan step: first close a running token, then classify the byte itself.
   always_comb begin
      mode_in       = mode_ff;
      kw_in         = kw_ff;
      cur_line_in   = cur_line_ff;
      cur_col_in    = cur_col_ff;
      cur_ofs_in    = cur_ofs_ff;
      start_line_in = start_line_ff;
      start_col_in  = start_col_ff;
      start_ofs_in  = start_ofs_ff;
      do_scan       = 1'b1;
      have_first    = 1'b0;
      have_scan     = 1'b0;
      first_tok     = '0;
      scan_tok      = '0;

      unique case (mode_ff)
         MODE_IDENT: begin
            if (is_word(req_ch)) begin
               if (!kw_match) begin
                  kw_in = KW_NONE;
               end
               cur_line_in = adv_line;
               cur_col_in  = adv_col;
               cur_ofs_in  = adv_ofs;
               do_scan     = 1'b0;
            end else begin
               first_tok  = make_token(kw_done ? KIND_KEYWORD : KIND_IDENT, start_line_ff,
                                       start_col_ff, start_ofs_ff, len, '0);
               have_first = 1'b1;
               mode_in    = MODE_IDLE;
               kw_in      = KW_NONE;
            end
         end
         MODE_NUMBER: begin
            if (is_digit(req_ch)) begin
               cur_line_in = adv_line;
               cur_col_in  = adv_col;
               cur_ofs_in  = adv_ofs;
               do_scan     = 1'b0;
            end else begin
               first_tok  = make_token(KIND_INTEGER, start_line_ff, start_col_ff,
                                       start_ofs_ff, len, '0);
               have_first = 1'b1;
               mode_in    = MODE_IDLE;
            end
         end
         MODE_STRING: begin
            if (req_ch == "\"") begin
               first_tok   = make_token(KIND_STRING, start_line_ff, start_col_ff,
                                        start_ofs_ff, len, '0);
               have_first  = 1'b1;
               mode_in     = MODE_IDLE;
               cur_line_in = adv_line;
               cur_col_in  = adv_col;
               cur_ofs_in  = adv_ofs;
               do_scan     = 1'b0;
            end else if (req_ch != 8'd0) begin
               cur_line_in = adv_line;
               cur_col_in  = adv_col;
               cur_ofs_in  = adv_ofs;
               do_scan     = 1'b0;
            end else begin
               first_tok  = make_token(KIND_UNTERM, start_line_ff, start_col_ff,
                                       start_ofs_ff, len, '0);
               have_first = 1'b1;
               mode_in    = MODE_IDLE;
            end
         end
         default: begin
         end
      endcase

      if (do_scan) begin
         if (req_ch == 8'd0) begin
            // End of text: report it and restart the position counters.
            scan_tok    = make_token(KIND_END, cur_line_ff, cur_col_ff, cur_ofs_ff,
                                     '0, '0);
            have_scan   = 1'b1;
            cur_line_in = POS_ONE;
            cur_col_in  = POS_ONE;
            cur_ofs_in  = '0;
            kw_in       = KW_NONE;
         end else if (is_space(req_ch)) begin
            cur_line_in = adv_line;
            cur_col_in  = adv_col;
            cur_ofs_in  = adv_ofs;
         end else if (is_alpha(req_ch) || req_ch == "_") begin
            start_line_in = cur_line_ff;
            start_col_in  = cur_col_ff;
            start_ofs_in  = cur_ofs_ff;
            kw_in         = (req_ch == "i") ? KW_INT :
                            (req_ch == "r") ? KW_RETURN : KW_NONE;
            mode_in       = MODE_IDENT;
            cur_line_in   = adv_line;
            cur_col_in    = adv_col;
            cur_ofs_in    = adv_ofs;
         end else if (is_digit(req_ch)) begin
            start_line_in = cur_line_ff;
            start_col_in  = cur_col_ff;
            start_ofs_in  = cur_ofs_ff;
            mode_in       = MODE_NUMBER;
            cur_line_in   = adv_line;
            cur_col_in    = adv_col;
            cur_ofs_in    = adv_ofs;
         end else if (req_ch == "\"") begin
            // The string text starts after the opening quote.
            start_line_in = cur_line_ff;
            start_col_in  = cur_col_ff;
            start_ofs_in  = adv_ofs;
            mode_in       = MODE_STRING;
            cur_line_in   = adv_line;
            cur_col_in    = adv_col;
            cur_ofs_in    = adv_ofs;
         end else begin
            // Single-character operator, punctuator or unknown byte.
            scan_tok    = make_token(
                             (req_ch == "+" || req_ch == "-" || req_ch == "*" ||
                              req_ch == "/" || req_ch == "=") ? KIND_OPERATOR :
                             (req_ch == ";") ? KIND_PUNCT : KIND_UNKNOWN,
                             cur_line_ff, cur_col_ff, cur_ofs_ff,
                             OFFSET_WIDTH'(1), req_ch);
            have_scan   = 1'b1;
            cur_line_in = adv_line;
            cur_col_in  = adv_col;
            cur_ofs_in  = adv_ofs;
         end
      end
   end

   // Event towards the queue: closed token first, then the byte's own token.
   always_comb begin
      evt_valid = accept && (have_first || have_scan);
      if (have_first) begin
         evt.two    = have_scan;
         evt.first  = first_tok;
         evt.second = scan_tok;
      end else begin
         evt.two    = 1'b0;
         evt.first  = scan_tok;
         evt.second = '0;
      end
   end

   // Scanner state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         kw_ff         <= KW_NONE;
         cur_line_ff   <= POS_ONE;
         cur_col_ff    <= POS_ONE;
         cur_ofs_ff    <= '0;
         start_line_ff <= POS_ONE;
         start_col_ff  <= POS_ONE;
         start_ofs_ff  <= '0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         kw_ff         <= kw_in;
         cur_line_ff   <= cur_line_in;
         cur_col_ff    <= cur_col_in;
         cur_ofs_ff    <= cur_ofs_in;
         start_line_ff <= start_line_in;
         start_col_ff  <= start_col_in;
         start_ofs_ff  <= start_ofs_in;
      end
   end

endmodule

// File: src/stt_queue.sv
// ----------------------------------------------------------------------------
// Tokenizer event queue
// A short first-in first-out store of events that lets the scanner run on
// while the result side is stalled.
// ----------------------------------------------------------------------------
module stt_queue
   import stt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_valid,
   input  event_type wr_data,
   output logic      full_q,
   input  logic      rd_take,
   output logic      rd_valid,
   output event_type rd_data
);

   localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

   event_type          store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_wr, do_rd;

   assign full_q   = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = store_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && !full_q;
   assign do_rd    = rd_take && rd_valid;

   // Pointer and fill count update, pointers wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: src/stt_back.sv
// ----------------------------------------------------------------------------
// Tokenizer result stage
// Holds the event at the head of the result channel and delivers its tokens
// one per pop, marking the last token of each request.
// ----------------------------------------------------------------------------
module stt_back
   import stt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  event_type           q_data,
   output logic                q_take,
   output logic                empty,
   input  logic                pop,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [POS_W-1:0]    rsp_tok_line,
   output logic [POS_W-1:0]    rsp_tok_column,
   output logic [OUT_W-1:0]    rsp_value_offset,
   output logic [OUT_W-1:0]    rsp_value_length,
   output logic [CHAR_W-1:0]   rsp_tok_char,
   output logic                rsp_last
);

   event_type entry_ff;
   logic      valid_ff, valid_in;
   logic      second_ff, second_in;
   logic      finishing;
   token_type cur_tok;

   // The held event is done once its final token is popped.
   assign finishing = second_ff || !entry_ff.two;
   assign q_take    = !valid_ff || (pop && finishing);

   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      if (q_take) begin
         valid_in  = q_valid;
         second_in = 1'b0;
      end else if (pop) begin
         second_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_take && q_valid) begin
         entry_ff <= q_data;
      end
   end

   // Result ports.
   assign cur_tok          = second_ff ? entry_ff.second : entry_ff.first;
   assign empty            = !valid_ff;
   assign rsp_kind         = cur_tok.kind;
   assign rsp_tok_line     = cur_tok.line;
   assign rsp_tok_column   = cur_tok.column;
   assign rsp_value_offset = cur_tok.offset;
   assign rsp_value_length = cur_tok.length;
   assign rsp_tok_char     = cur_tok.chr;
   assign rsp_last         = finishing;

endmodule

// File: src/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// Source text tokenizer
// Streaming lexical scanner for source text, one byte per request.
// ----------------------------------------------------------------------------
// The block takes one source byte per cycle while full is low and gives one
// token per cycle while the receiver pops; byte 0 ends a text and restarts
// line, column and offset. A byte that closes an identifier, integer or
// unterminated string and is itself a token gives two results, the second
// marked last. The scanner writes a request's tokens into a four-event queue
// when it accepts the byte, and the result stage loads the queue head into
// its own register when it is empty or when the last token of its held event is popped.
// Full rises only when that queue holds four events, so bytes that give no
// token (inside a word, number or string, or whitespace) keep flowing while
// the result side is stalled.
module source_text_tokenizer
   import stt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [CHAR_W-1:0]   req_ch,
   output logic                empty,
   input  logic                pop,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [POS_W-1:0]    rsp_tok_line,
   output logic [POS_W-1:0]    rsp_tok_column,
   output logic [OUT_W-1:0]    rsp_value_offset,
   output logic [OUT_W-1:0]    rsp_value_length,
   output logic [CHAR_W-1:0]   rsp_tok_char,
   output logic                rsp_last
);

   logic      evt_valid;
   event_type evt;
   logic      q_take, q_valid;
   event_type q_data;

   // Scanner.
   stt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .req_ch     (req_ch),
      .queue_full (full),
      .evt_valid  (evt_valid),
      .evt        (evt)
   );

   // Event queue.
   stt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (evt_valid),
      .wr_data  (evt),
      .full_q   (full),
      .rd_take  (q_take),
      .rd_valid (q_valid),
      .rd_data  (q_data)
   );

   // Result stage.
   stt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_data           (q_data),
      .q_take           (q_take),
      .empty            (empty),
      .pop              (pop),
      .rsp_kind         (rsp_kind),
      .rsp_tok_line     (rsp_tok_line),
      .rsp_tok_column   (rsp_tok_column),
      .rsp_value_offset (rsp_value_offset),
      .rsp_value_length (rsp_value_length),
      .rsp_tok_char     (rsp_tok_char),
      .rsp_last         (rsp_last)
   );

endmodule

// File: src/stt_checker.sv
// ----------------------------------------------------------------------------
// Source text tokenizer checker
// Port-level assertions on the tokenizer, attached to the top level.
// ----------------------------------------------------------------------------
module stt_checker
   import stt_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                empty,
   input logic                pop,
   input logic [KIND_W-1:0]   rsp_kind,
   input logic [POS_W-1:0]    rsp_tok_line,
   input logic [POS_W-1:0]    rsp_tok_column,
   input logic [OUT_W-1:0]    rsp_value_offset,
   input logic [OUT_W-1:0]    rsp_value_length,
   input logic [CHAR_W-1:0]   rsp_tok_char,
   input logic                rsp_last
);

   // Nothing is offered straight after reset.
   assert property (@(posedge clock) reset |=> empty)
      else $error("result offered after reset");

   // A waiting result holds until it is popped.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_kind) && $stable(rsp_tok_line)
         && $stable(rsp_tok_column) && $stable(rsp_value_offset)
         && $stable(rsp_value_length) && $stable(rsp_last)))
      else $error("waiting result changed before pop");

   // An end of text closes its request and carries no text.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind == KIND_END) |-> (rsp_last && rsp_value_length == '0
         && rsp_tok_char == '0))
      else $error("malformed end of text result");

   // A result that is not last is always a closed word or number, or an unterminated string.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_last) |-> (rsp_kind == KIND_KEYWORD || rsp_kind == KIND_IDENT
         || rsp_kind == KIND_INTEGER || rsp_kind == KIND_UNTERM))
      else $error("unexpected first of two results");

   // Single-character tokens have a length of one, are last, and have a nonzero line and column.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_kind == KIND_OPERATOR || rsp_kind == KIND_PUNCT
         || rsp_kind == KIND_UNKNOWN)) |-> (rsp_value_length == OUT_W'(1)
         && rsp_last && rsp_tok_line != '0 && rsp_tok_column != '0))
      else $error("malformed single-character token");

endmodule

bind source_text_tokenizer stt_checker u_checker (.*);
